// ----- design/lag2d_pkg.sv -----
// ----------------------------------------------------------------------------
// Lagrange 2D shape evaluator: shared package
// Fixed-point types, operation codes, stage records and rounding helpers used
// by every stage of the shape function pipeline.
// ----------------------------------------------------------------------------
package lag2d_pkg;

  // Fraction bits of coordinates, intermediates and results.
  localparam int COORD_FRAC_BITS = 14;
  localparam int COORD_W         = 16;
  localparam int VALUE_W         = 19;
  localparam int STATUS_W        = 2;

  // Working width: coordinate range times the largest factor in any formula.
  localparam int OPND_W = ((COORD_FRAC_BITS > COORD_W - 1) ? COORD_FRAC_BITS : COORD_W - 1) + 7;
  localparam int POST_W = OPND_W + 3;
  localparam int PROD_W = 2 * OPND_W;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [POST_W-1:0] post_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam opnd_t ONE      = opnd_t'(1) <<< COORD_FRAC_BITS;
  localparam opnd_t HALF_ONE = opnd_t'(1) <<< (COORD_FRAC_BITS - 1);
  localparam opnd_t OPND_LSB = opnd_t'(1);
  localparam prod_t PROD_RND = prod_t'(1) <<< (COORD_FRAC_BITS - 1);
  localparam post_t POST_LSB = post_t'(1);
  localparam post_t POST_TWO = post_t'(2);
  localparam post_t VALUE_MAX = (post_t'(1) <<< (VALUE_W - 1)) - post_t'(1);
  localparam post_t VALUE_MIN = -(post_t'(1) <<< (VALUE_W - 1));

  // Element kinds.
  localparam logic [2:0] KIND_QUAD4 = 3'd0;
  localparam logic [2:0] KIND_QUAD8 = 3'd1;
  localparam logic [2:0] KIND_QUAD9 = 3'd2;
  localparam logic [2:0] KIND_TRI3  = 3'd3;
  localparam logic [2:0] KIND_TRI6  = 3'd4;

  // Orders.
  localparam logic ORDER_LINEAR    = 1'b0;
  localparam logic ORDER_QUADRATIC = 1'b1;

  // Actions.
  localparam logic [1:0] ACT_VALUE = 2'd0;
  localparam logic [1:0] ACT_DXI   = 2'd1;
  localparam logic [1:0] ACT_DETA  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_NODE    = 2'd2;

  // Tensor node positions along xi and eta (0 low end, 1 high end, 2 middle).
  localparam logic [1:0] Q9_XI_NODE  [9] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2};
  localparam logic [1:0] Q9_ETA_NODE [9] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2, 2'd2};

  // Treatment of a lane product before the second multiplication.
  typedef enum logic [1:0] {
    LANE_ID,
    LANE_HALF,
    LANE_ONE_MINUS
  } lane_op_t;

  // Treatment of the final product.
  typedef enum logic [2:0] {
    POST_ID,
    POST_HALF,
    POST_QUARTER,
    POST_NEG_HALF,
    POST_TWICE,
    POST_FOUR_TIMES
  } post_op_t;

  // Decoded word: two lane products and what follows them.
  typedef struct packed {
    opnd_t                a;
    opnd_t                b;
    opnd_t                e;
    opnd_t                g;
    lane_op_t             op1;
    lane_op_t             op2;
    post_op_t             post;
    logic [STATUS_W-1:0]  status;
  } job_t;

  // Operands of the second multiplication.
  typedef struct packed {
    opnd_t                c;
    opnd_t                d;
    post_op_t             post;
    logic [STATUS_W-1:0]  status;
  } mid_t;

  // Final product awaiting scaling and saturation.
  typedef struct packed {
    opnd_t                p;
    post_op_t             post;
    logic [STATUS_W-1:0]  status;
  } fin_t;

  // Fixed-point product, rounded to nearest with ties toward plus infinity.
  function automatic opnd_t fmul(opnd_t a, opnd_t b);
    prod_t p;
    p = a * b;
    p = p + PROD_RND;
    return opnd_t'(p >>> COORD_FRAC_BITS);
  endfunction

  // Halving with the same rounding.
  function automatic opnd_t half_rnd(opnd_t v);
    return (v + OPND_LSB) >>> 1;
  endfunction

endpackage

// ----- design/lag2d_decode.sv -----
// ----------------------------------------------------------------------------
// Lagrange 2D shape evaluator: request decoder
// Checks the request, then maps the chosen formula onto two lane products and
// a final scaling, and registers the result as the first pipeline stage.
// ----------------------------------------------------------------------------
module lag2d_decode (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2:0]                           element_kind,
  input  logic                                 element_order,
  input  logic [3:0]                           node_index,
  input  logic [1:0]                           action,
  input  logic signed [lag2d_pkg::COORD_W-1:0] xi_coord,
  input  logic signed [lag2d_pkg::COORD_W-1:0] eta_coord,
  output logic                                 job_valid,
  output lag2d_pkg::job_t                      job
);

  typedef struct packed {
    lag2d_pkg::opnd_t    a;
    lag2d_pkg::opnd_t    b;
    lag2d_pkg::lane_op_t op;
  } factor_t;

  // One-dimensional factor of a tensor element along one axis.
  function automatic factor_t factor(logic quadratic, logic [1:0] n, logic deriv,
                                     lag2d_pkg::opnd_t v);
    factor_t f;
    f.a  = '0;
    f.b  = lag2d_pkg::ONE;
    f.op = lag2d_pkg::LANE_ID;
    if (!quadratic) begin
      if (deriv) begin
        f.a = n[0] ? lag2d_pkg::HALF_ONE : -lag2d_pkg::HALF_ONE;
      end else begin
        f.a = n[0] ? lag2d_pkg::half_rnd(lag2d_pkg::ONE + v)
                   : lag2d_pkg::half_rnd(lag2d_pkg::ONE - v);
      end
    end else if (deriv) begin
      case (n)
        2'd0:    f.a = v - lag2d_pkg::HALF_ONE;
        2'd1:    f.a = v + lag2d_pkg::HALF_ONE;
        default: f.a = -(v <<< 1);
      endcase
    end else begin
      f.a = v;
      case (n)
        2'd0: begin
          f.b  = v - lag2d_pkg::ONE;
          f.op = lag2d_pkg::LANE_HALF;
        end
        2'd1: begin
          f.b  = v + lag2d_pkg::ONE;
          f.op = lag2d_pkg::LANE_HALF;
        end
        default: begin
          f.b  = v;
          f.op = lag2d_pkg::LANE_ONE_MINUS;
        end
      endcase
    end
    return f;
  endfunction

  lag2d_pkg::opnd_t x, y, xm, xp, ym, yp, z0;
  logic [3:0]       nodes;
  logic             act_ok;
  factor_t          fx, fy;
  lag2d_pkg::job_t  job_next;

  // Coordinates and the common terms of the formulas.
  always_comb begin
    x  = lag2d_pkg::opnd_t'(xi_coord);
    y  = lag2d_pkg::opnd_t'(eta_coord);
    xm = lag2d_pkg::ONE - x;
    xp = lag2d_pkg::ONE + x;
    ym = lag2d_pkg::ONE - y;
    yp = lag2d_pkg::ONE + y;
    z0 = lag2d_pkg::ONE - x - y;
  end

  // Tensor factors; only meaningful for the quadrilateral tensor cases.
  always_comb begin
    fx = factor(element_order, lag2d_pkg::Q9_XI_NODE[node_index],
                action == lag2d_pkg::ACT_DXI, x);
    fy = factor(element_order, lag2d_pkg::Q9_ETA_NODE[node_index],
                action == lag2d_pkg::ACT_DETA, y);
  end

  // Node count of each supported kind and order.
  always_comb begin
    nodes = 4'd0;
    if (element_order == lag2d_pkg::ORDER_LINEAR) begin
      unique case (element_kind) inside
        lag2d_pkg::KIND_QUAD4, lag2d_pkg::KIND_QUAD8, lag2d_pkg::KIND_QUAD9: nodes = 4'd4;
        lag2d_pkg::KIND_TRI3, lag2d_pkg::KIND_TRI6:                          nodes = 4'd3;
        default:                                                             nodes = 4'd0;
      endcase
    end else begin
      unique case (element_kind)
        lag2d_pkg::KIND_QUAD8: nodes = 4'd8;
        lag2d_pkg::KIND_QUAD9: nodes = 4'd9;
        lag2d_pkg::KIND_TRI6:  nodes = 4'd6;
        default:               nodes = 4'd0;
      endcase
    end
    act_ok = (action == lag2d_pkg::ACT_VALUE) || (action == lag2d_pkg::ACT_DXI) ||
             (action == lag2d_pkg::ACT_DETA);
  end

  // Formula selection.
  always_comb begin
    job_next.a      = '0;
    job_next.b      = lag2d_pkg::ONE;
    job_next.e      = lag2d_pkg::ONE;
    job_next.g      = lag2d_pkg::ONE;
    job_next.op1    = lag2d_pkg::LANE_ID;
    job_next.op2    = lag2d_pkg::LANE_ID;
    job_next.post   = lag2d_pkg::POST_ID;
    job_next.status = lag2d_pkg::STATUS_OK;
    if (nodes == 4'd0 || !act_ok) begin
      job_next.status = lag2d_pkg::STATUS_UNSUPPORTED;
    end else if (node_index >= nodes) begin
      job_next.status = lag2d_pkg::STATUS_BAD_NODE;
    end else if ((element_order == lag2d_pkg::ORDER_LINEAR &&
                  element_kind != lag2d_pkg::KIND_TRI3 &&
                  element_kind != lag2d_pkg::KIND_TRI6) ||
                 element_kind == lag2d_pkg::KIND_QUAD9) begin
      // Tensor product of one-dimensional factors.
      job_next.a   = fx.a;
      job_next.b   = fx.b;
      job_next.op1 = fx.op;
      job_next.e   = fy.a;
      job_next.g   = fy.b;
      job_next.op2 = fy.op;
    end else if (element_order == lag2d_pkg::ORDER_LINEAR) begin
      // Linear triangle.
      if (action == lag2d_pkg::ACT_VALUE) begin
        case (node_index)
          4'd0:    job_next.a = z0;
          4'd1:    job_next.a = x;
          default: job_next.a = y;
        endcase
      end else begin
        case (node_index)
          4'd0:    job_next.a = -lag2d_pkg::ONE;
          4'd1:    job_next.a = (action == lag2d_pkg::ACT_DXI) ? lag2d_pkg::ONE : '0;
          default: job_next.a = (action == lag2d_pkg::ACT_DETA) ? lag2d_pkg::ONE : '0;
        endcase
      end
    end else if (element_kind == lag2d_pkg::KIND_QUAD8) begin
      // Serendipity quadrilateral.
      if (action == lag2d_pkg::ACT_VALUE) begin
        case (node_index)
          4'd0: begin
            job_next.a = xm; job_next.b = ym; job_next.e = -lag2d_pkg::ONE - x - y;
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd1: begin
            job_next.a = xp; job_next.b = ym; job_next.e = -lag2d_pkg::ONE + x - y;
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd2: begin
            job_next.a = xp; job_next.b = yp; job_next.e = -lag2d_pkg::ONE + x + y;
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd3: begin
            job_next.a = xm; job_next.b = yp; job_next.e = -lag2d_pkg::ONE - x + y;
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd4: begin
            job_next.a = x; job_next.b = x; job_next.op1 = lag2d_pkg::LANE_ONE_MINUS;
            job_next.e = ym; job_next.post = lag2d_pkg::POST_HALF;
          end
          4'd5: begin
            job_next.a = xp; job_next.e = y; job_next.g = y;
            job_next.op2 = lag2d_pkg::LANE_ONE_MINUS; job_next.post = lag2d_pkg::POST_HALF;
          end
          4'd6: begin
            job_next.a = x; job_next.b = x; job_next.op1 = lag2d_pkg::LANE_ONE_MINUS;
            job_next.e = yp; job_next.post = lag2d_pkg::POST_HALF;
          end
          default: begin
            job_next.a = xm; job_next.e = y; job_next.g = y;
            job_next.op2 = lag2d_pkg::LANE_ONE_MINUS; job_next.post = lag2d_pkg::POST_HALF;
          end
        endcase
      end else if (action == lag2d_pkg::ACT_DXI) begin
        case (node_index)
          4'd0: begin
            job_next.a = ym; job_next.b = -xm - (-lag2d_pkg::ONE - x - y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd1: begin
            job_next.a = ym; job_next.b = xp + (-lag2d_pkg::ONE + x - y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd2: begin
            job_next.a = yp; job_next.b = xp + (-lag2d_pkg::ONE + x + y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd3: begin
            job_next.a = yp; job_next.b = -xm - (-lag2d_pkg::ONE - x + y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd4: begin
            job_next.a = -x; job_next.b = ym;
          end
          4'd5: begin
            job_next.a = y; job_next.b = y; job_next.op1 = lag2d_pkg::LANE_ONE_MINUS;
            job_next.post = lag2d_pkg::POST_HALF;
          end
          4'd6: begin
            job_next.a = -x; job_next.b = yp;
          end
          default: begin
            job_next.a = y; job_next.b = y; job_next.op1 = lag2d_pkg::LANE_ONE_MINUS;
            job_next.post = lag2d_pkg::POST_NEG_HALF;
          end
        endcase
      end else begin
        case (node_index)
          4'd0: begin
            job_next.a = xm; job_next.b = -ym - (-lag2d_pkg::ONE - x - y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd1: begin
            job_next.a = xp; job_next.b = -ym - (-lag2d_pkg::ONE + x - y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd2: begin
            job_next.a = xp; job_next.b = yp + (-lag2d_pkg::ONE + x + y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd3: begin
            job_next.a = xm; job_next.b = yp + (-lag2d_pkg::ONE - x + y);
            job_next.post = lag2d_pkg::POST_QUARTER;
          end
          4'd4: begin
            job_next.a = x; job_next.b = x; job_next.op1 = lag2d_pkg::LANE_ONE_MINUS;
            job_next.post = lag2d_pkg::POST_NEG_HALF;
          end
          4'd5: begin
            job_next.a = xp; job_next.b = -y;
          end
          4'd6: begin
            job_next.a = x; job_next.b = x; job_next.op1 = lag2d_pkg::LANE_ONE_MINUS;
            job_next.post = lag2d_pkg::POST_HALF;
          end
          default: begin
            job_next.a = xm; job_next.b = -y;
          end
        endcase
      end
    end else begin
      // Quadratic triangle in area coordinates z0, z1 = xi, z2 = eta.
      if (action == lag2d_pkg::ACT_VALUE) begin
        case (node_index)
          4'd0: begin
            job_next.a = z0; job_next.b = z0 - lag2d_pkg::HALF_ONE;
            job_next.post = lag2d_pkg::POST_TWICE;
          end
          4'd1: begin
            job_next.a = x; job_next.b = x - lag2d_pkg::HALF_ONE;
            job_next.post = lag2d_pkg::POST_TWICE;
          end
          4'd2: begin
            job_next.a = y; job_next.b = y - lag2d_pkg::HALF_ONE;
            job_next.post = lag2d_pkg::POST_TWICE;
          end
          4'd3: begin
            job_next.a = z0; job_next.b = x; job_next.post = lag2d_pkg::POST_FOUR_TIMES;
          end
          4'd4: begin
            job_next.a = x; job_next.b = y; job_next.post = lag2d_pkg::POST_FOUR_TIMES;
          end
          default: begin
            job_next.a = y; job_next.b = z0; job_next.post = lag2d_pkg::POST_FOUR_TIMES;
          end
        endcase
      end else if (action == lag2d_pkg::ACT_DXI) begin
        case (node_index)
          4'd0:    job_next.a = -((z0 <<< 2) - lag2d_pkg::ONE);
          4'd1:    job_next.a = (x <<< 2) - lag2d_pkg::ONE;
          4'd2:    job_next.a = '0;
          4'd3:    job_next.a = (z0 <<< 2) - (x <<< 2);
          4'd4:    job_next.a = y <<< 2;
          default: job_next.a = -(y <<< 2);
        endcase
      end else begin
        case (node_index)
          4'd0:    job_next.a = -((z0 <<< 2) - lag2d_pkg::ONE);
          4'd1:    job_next.a = '0;
          4'd2:    job_next.a = (y <<< 2) - lag2d_pkg::ONE;
          4'd3:    job_next.a = -(x <<< 2);
          4'd4:    job_next.a = x <<< 2;
          default: job_next.a = (z0 <<< 2) - (y <<< 2);
        endcase
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (en) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job <= job_next;
    end
  end

endmodule

// ----- design/lag2d_lane.sv -----
// ----------------------------------------------------------------------------
// Lagrange 2D shape evaluator: lane products
// Forms the two first-level products in parallel and applies each lane's
// halving or one-minus step before they meet in the final multiplier.
// ----------------------------------------------------------------------------
module lag2d_lane (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            job_valid,
  input  lag2d_pkg::job_t job,
  output logic            mid_valid,
  output lag2d_pkg::mid_t mid
);

  lag2d_pkg::opnd_t m1, m2;
  lag2d_pkg::mid_t  mid_next;

  // Shared lane step after a rounded product.
  function automatic lag2d_pkg::opnd_t lane_step(lag2d_pkg::lane_op_t op,
                                                 lag2d_pkg::opnd_t v);
    lag2d_pkg::opnd_t r;
    case (op)
      lag2d_pkg::LANE_HALF:      r = lag2d_pkg::half_rnd(v);
      lag2d_pkg::LANE_ONE_MINUS: r = lag2d_pkg::ONE - v;
      default:                   r = v;
    endcase
    return r;
  endfunction

  // Two independent multipliers.
  always_comb begin
    m1              = lag2d_pkg::fmul(job.a, job.b);
    m2              = lag2d_pkg::fmul(job.e, job.g);
    mid_next.c      = lane_step(job.op1, m1);
    mid_next.d      = lane_step(job.op2, m2);
    mid_next.post   = job.post;
    mid_next.status = job.status;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid <= mid_next;
    end
  end

endmodule

// ----- design/lag2d_mul.sv -----
// ----------------------------------------------------------------------------
// Lagrange 2D shape evaluator: final multiplier
// Multiplies the two lane results with rounding and registers the product.
// ----------------------------------------------------------------------------
module lag2d_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            mid_valid,
  input  lag2d_pkg::mid_t mid,
  output logic            fin_valid,
  output lag2d_pkg::fin_t fin
);

  lag2d_pkg::fin_t fin_next;

  // Second-level product.
  always_comb begin
    fin_next.p      = lag2d_pkg::fmul(mid.c, mid.d);
    fin_next.post   = mid.post;
    fin_next.status = mid.status;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_next;
    end
  end

endmodule

// ----- design/lag2d_post.sv -----
// ----------------------------------------------------------------------------
// Lagrange 2D shape evaluator: output stage
// Applies the final scaling, forces rejected requests to zero, saturates to
// the result width and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module lag2d_post (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  fin_valid,
  input  lag2d_pkg::fin_t                       fin,
  output logic                                  out_valid,
  output logic signed [lag2d_pkg::VALUE_W-1:0]  shape_value,
  output logic [lag2d_pkg::STATUS_W-1:0]        status
);

  lag2d_pkg::post_t w, r, sat;

  // Scaling and saturation.
  always_comb begin
    w = lag2d_pkg::post_t'(fin.p);
    case (fin.post)
      lag2d_pkg::POST_HALF:       r = (w + lag2d_pkg::POST_LSB) >>> 1;
      lag2d_pkg::POST_QUARTER:    r = (w + lag2d_pkg::POST_TWO) >>> 2;
      lag2d_pkg::POST_NEG_HALF:   r = -((w + lag2d_pkg::POST_LSB) >>> 1);
      lag2d_pkg::POST_TWICE:      r = w <<< 1;
      lag2d_pkg::POST_FOUR_TIMES: r = w <<< 2;
      default:                    r = w;
    endcase
    if (fin.status != lag2d_pkg::STATUS_OK) begin
      sat = '0;
    end else if (r > lag2d_pkg::VALUE_MAX) begin
      sat = lag2d_pkg::VALUE_MAX;
    end else if (r < lag2d_pkg::VALUE_MIN) begin
      sat = lag2d_pkg::VALUE_MIN;
    end else begin
      sat = r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shape_value <= sat[lag2d_pkg::VALUE_W-1:0];
      status      <= fin.status;
    end
  end

endmodule

// ----- design/lagrange_2d_shape_eval.sv -----
// ----------------------------------------------------------------------------
// Lagrange 2D shape evaluator: top level
// Evaluates one Lagrange shape function or first derivative per word.
// ----------------------------------------------------------------------------
// The block takes one request word per cycle while the output is not stalled and
// returns its result word through the registered stages: decode, two parallel lane
// multipliers, the final multiplier, then scaling and saturation in the output
// register. The two chained rounded multiplications set the pipeline depth. All
// stages advance together; when the output word is held by out_stall, the whole
// pipeline holds and in_stall is raised, so no word is lost or repeated. Rejected
// requests return zero with a nonzero status.
module lagrange_2d_shape_eval (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            element_kind,
  input  logic                                  element_order,
  input  logic [3:0]                            node_index,
  input  logic [1:0]                            action,
  input  logic signed [lag2d_pkg::COORD_W-1:0]  xi_coord,
  input  logic signed [lag2d_pkg::COORD_W-1:0]  eta_coord,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lag2d_pkg::VALUE_W-1:0]  shape_value,
  output logic [lag2d_pkg::STATUS_W-1:0]        status
);

  logic            advance;
  logic            job_valid, mid_valid, fin_valid;
  lag2d_pkg::job_t job;
  lag2d_pkg::mid_t mid;
  lag2d_pkg::fin_t fin;

  // The pipeline moves unless a finished word is waiting at the output.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  lag2d_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .in_valid      (in_valid),
    .element_kind  (element_kind),
    .element_order (element_order),
    .node_index    (node_index),
    .action        (action),
    .xi_coord      (xi_coord),
    .eta_coord     (eta_coord),
    .job_valid     (job_valid),
    .job           (job)
  );

  lag2d_lane u_lane (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .job_valid (job_valid),
    .job       (job),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  lag2d_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .mid_valid (mid_valid),
    .mid       (mid),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  lag2d_post u_post (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .fin_valid   (fin_valid),
    .fin         (fin),
    .out_valid   (out_valid),
    .shape_value (shape_value),
    .status      (status)
  );

endmodule

// ----- design/lag2d_checker.sv -----
// ----------------------------------------------------------------------------
// Lagrange 2D shape evaluator: port checker
// Watches the top-level ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
module lag2d_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [lag2d_pkg::VALUE_W-1:0]  shape_value,
  input logic [lag2d_pkg::STATUS_W-1:0]        status
);

  // A rejected request always carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != lag2d_pkg::STATUS_OK) |-> shape_value == '0)
    else $error("rejected word with nonzero value");

  // Input is only held back by a waiting output word.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // Only the defined status codes appear.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == lag2d_pkg::STATUS_OK || status == lag2d_pkg::STATUS_UNSUPPORTED ||
                   status == lag2d_pkg::STATUS_BAD_NODE))
    else $error("undefined status code");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(shape_value) && $stable(status)))
    else $error("stalled result word changed");

endmodule

bind lagrange_2d_shape_eval lag2d_checker u_checker (.*);
